// ----- rtl/pis_pkg.sv -----
// Shared constants, codes and control types of the predecoded instruction store.
`timescale 1ns / 1ps
package pis_pkg;

    localparam int unsigned WORDS_IN_PAGE     = 1024;
    localparam int unsigned PAGE_BITS         = 12;
    localparam int unsigned WORD_BITS         = 10;
    localparam int unsigned DEF_COVERED_PAGES = 16;

    localparam logic [2:0] ACT_LOOKUP    = 3'd0;
    localparam logic [2:0] ACT_FILL      = 3'd1;
    localparam logic [2:0] ACT_INV_PAGE  = 3'd2;
    localparam logic [2:0] ACT_INV_RANGE = 3'd3;
    localparam logic [2:0] ACT_CLEAR_ALL = 3'd4;

    typedef enum logic [0:0] {
        ST_READY = 1'b0,
        ST_SWEEP = 1'b1
    } state_t;

    typedef struct packed {
        logic accept;
        logic s1_advance;
        logic out_take;
        logic sweep_load;
        logic sweep_step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic s1_valid;
        logic out_valid;
        logic sweep_needed;
        logic sweep_done;
    } dp_status_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] op_id;
        logic [31:0] word;
    } entry_t;

endpackage

// ----- rtl/pis_ctrl.sv -----
// Controller state machine: handshake, pipeline advance and sweep sequencing.
`timescale 1ns / 1ps
module pis_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   out_stall,
    input  pis_pkg::dp_status_t    status,
    output pis_pkg::ctrl_cmd_t     cmd
);
    import pis_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   can_accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.s1_advance  = status.s1_valid && (!status.out_valid || !out_stall);
        cmd.out_take    = status.out_valid && !out_stall;
        can_accept      = 1'b0;
        unique case (state_reg)
            ST_READY:
            begin
                can_accept     = !status.s1_valid || cmd.s1_advance;
                cmd.accept     = in_valid && can_accept;
                cmd.sweep_load = cmd.accept && status.sweep_needed;
                if (cmd.sweep_load)
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_done)
                begin
                    state_next = ST_READY;
                end
            end
            default:
            begin
                state_next = ST_READY;
            end
        endcase
        in_stall = !can_accept;
    end

endmodule

// ----- rtl/pis_datapath.sv -----
// Datapath: entry memory, address decode, sweep counter and result registers.
`timescale 1ns / 1ps
module pis_datapath #(
    parameter int unsigned COVERED_PAGES = pis_pkg::DEF_COVERED_PAGES
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pis_pkg::ctrl_cmd_t   cmd,
    output pis_pkg::dp_status_t  status,
    input  logic [2:0]           action,
    input  logic [31:0]          phys_addr,
    input  logic [31:0]          range_length,
    input  logic [31:0]          fill_word,
    input  logic [7:0]           fill_op_id,
    output logic                 out_valid,
    output logic                 hit,
    output logic [31:0]          hit_word,
    output logic [7:0]           hit_op_id
);
    import pis_pkg::*;

    localparam int unsigned DEPTH = COVERED_PAGES * WORDS_IN_PAGE;
    localparam int unsigned PG_W  = (COVERED_PAGES > 1) ? $clog2(COVERED_PAGES) : 1;
    localparam int unsigned IDX_W = PG_W + WORD_BITS;
    localparam logic [19:0] PAGES_C    = 20'(COVERED_PAGES);
    localparam logic [19:0] LAST_PAGE  = 20'(COVERED_PAGES - 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    entry_t mem [DEPTH];
    entry_t rd_reg;

    logic [19:0]      addr_page;
    logic             covered;
    logic [IDX_W-1:0] addr_idx;
    logic [32:0]      range_end;
    logic [19:0]      end_page;
    logic [19:0]      end_page_clamped;
    logic             is_lookup;
    logic             is_fill;
    logic             sweep_needed;

    logic             s1_valid_reg;
    logic             s1_lookup_reg;
    logic             out_valid_reg;
    logic             hit_reg;
    logic [31:0]      hit_word_reg;
    logic [7:0]       hit_op_id_reg;

    logic [IDX_W-1:0] sweep_idx_reg;
    logic [IDX_W-1:0] sweep_last_reg;
    logic [IDX_W-1:0] sweep_first;
    logic [IDX_W-1:0] sweep_last;

    assign addr_page = phys_addr[31:PAGE_BITS];
    assign covered   = addr_page < PAGES_C;
    assign addr_idx  = {addr_page[PG_W-1:0], phys_addr[PAGE_BITS-1:2]};
    assign is_lookup = action == ACT_LOOKUP;
    assign is_fill   = action == ACT_FILL;

    assign range_end        = {1'b0, phys_addr} + {1'b0, range_length} - 33'd1;
    assign end_page         = range_end[32] ? 20'hFFFFF : range_end[31:PAGE_BITS];
    assign end_page_clamped = (end_page > LAST_PAGE) ? LAST_PAGE : end_page;

    always_comb
    begin
        sweep_needed = 1'b0;
        sweep_first  = '0;
        sweep_last   = LAST_IDX;
        unique case (action)
            ACT_INV_PAGE:
            begin
                sweep_needed = covered;
                sweep_first  = {addr_page[PG_W-1:0], {WORD_BITS{1'b0}}};
                sweep_last   = {addr_page[PG_W-1:0], {WORD_BITS{1'b1}}};
            end
            ACT_INV_RANGE:
            begin
                sweep_needed = covered && (range_length != 32'd0);
                sweep_first  = {addr_page[PG_W-1:0], {WORD_BITS{1'b0}}};
                sweep_last   = {end_page_clamped[PG_W-1:0], {WORD_BITS{1'b1}}};
            end
            ACT_CLEAR_ALL:
            begin
                sweep_needed = 1'b1;
            end
            default:
            begin
                sweep_needed = 1'b0;
            end
        endcase
    end

    assign status = '{s1_valid: s1_valid_reg,
                      out_valid: out_valid_reg,
                      sweep_needed: sweep_needed,
                      sweep_done: sweep_idx_reg == sweep_last_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.sweep_step)
        begin
            mem[sweep_idx_reg] <= '0;
        end
        else if (cmd.accept && is_fill && covered)
        begin
            mem[addr_idx] <= '{valid: fill_op_id != 8'd0, op_id: fill_op_id, word: fill_word};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && is_lookup && covered)
        begin
            rd_reg <= mem[addr_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_idx_reg  <= '0;
            sweep_last_reg <= LAST_IDX;
        end
        else if (cmd.sweep_load)
        begin
            sweep_idx_reg  <= sweep_first;
            sweep_last_reg <= sweep_last;
        end
        else if (cmd.sweep_step && !status.sweep_done)
        begin
            sweep_idx_reg <= sweep_idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (cmd.s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (cmd.s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (cmd.out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            s1_lookup_reg <= is_lookup && covered;
        end
        if (cmd.s1_advance)
        begin
            hit_reg       <= s1_lookup_reg && rd_reg.valid;
            hit_word_reg  <= (s1_lookup_reg && rd_reg.valid) ? rd_reg.word : 32'd0;
            hit_op_id_reg <= (s1_lookup_reg && rd_reg.valid) ? rd_reg.op_id : 8'd0;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign hit_word  = hit_word_reg;
    assign hit_op_id = hit_op_id_reg;

`ifndef SYNTHESIS
    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> !cmd.sweep_step)
        else $error("transfer accepted during sweep");

    a_sweep_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sweep_step |-> sweep_idx_reg <= sweep_last_reg)
        else $error("sweep index past end");

    a_hit_has_id: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && hit_reg) |-> hit_op_id_reg != 8'd0)
        else $error("hit with zero operation id");

    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !hit_reg) |-> (hit_word_reg == 32'd0 && hit_op_id_reg == 8'd0))
        else $error("miss result not zero");

    a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !cmd.s1_advance) |=> s1_valid_reg)
        else $error("pending transfer dropped");
`endif

endmodule

// ----- rtl/predecoded_instruction_store_core.sv -----
// The result passes the stage-1 register, then the output register; out_stall can hold it in either.
// Throughput: one lookup or fill per cycle while the output is not stalled and no sweep runs.
// Invalidations sweep one entry per cycle over whole pages of 1024 entries, up to the whole store.
// Clear all and reset sweep all COVERED_PAGES * 1024 entries; no input is taken meanwhile.
// Reset: asynchronous, active low; the post-reset sweep empties the store.
`timescale 1ns / 1ps
module predecoded_instruction_store_core #(
    parameter int unsigned COVERED_PAGES = pis_pkg::DEF_COVERED_PAGES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [31:0] phys_addr,
    input  logic [31:0] range_length,
    input  logic [31:0] fill_word,
    input  logic [7:0]  fill_op_id,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        hit,
    output logic [31:0] hit_word,
    output logic [7:0]  hit_op_id
);
    import pis_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    pis_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    pis_datapath #(
        .COVERED_PAGES (COVERED_PAGES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .action       (action),
        .phys_addr    (phys_addr),
        .range_length (range_length),
        .fill_word    (fill_word),
        .fill_op_id   (fill_op_id),
        .out_valid    (out_valid),
        .hit          (hit),
        .hit_word     (hit_word),
        .hit_op_id    (hit_op_id)
    );

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the predecoded instruction store: lookups, fills and invalidations.
`timescale 1ns / 1ps
module testbench;
    import pis_pkg::*;

    localparam int unsigned STORE_DEPTH = DEF_COVERED_PAGES * WORDS_IN_PAGE;
    localparam logic [2:0] ACT_RESERVED_A = 3'd5;
    localparam logic [2:0] ACT_RESERVED_B = 3'd6;
    localparam logic [2:0] ACT_RESERVED_C = 3'd7;
    localparam int unsigned RANDOM_REQUESTS = 400;
    localparam int unsigned SWEEP_BUDGET = 20;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] addr;
        logic [31:0] len;
        logic [31:0] word;
        logic [7:0]  op_id;
    } store_request_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] word;
        logic [7:0]  op_id;
    } store_reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  action = ACT_LOOKUP;
    logic [31:0] phys_addr = '0;
    logic [31:0] range_length = '0;
    logic [31:0] fill_word = '0;
    logic [7:0]  fill_op_id = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        hit;
    logic [31:0] hit_word;
    logic [7:0]  hit_op_id;

    bit          entry_live [STORE_DEPTH];
    logic [31:0] entry_word [STORE_DEPTH];
    logic [7:0]  entry_op [STORE_DEPTH];

    store_request_t pending_requests[$];
    store_reply_t   expected_replies[$];
    store_request_t cur_request = '0;
    store_request_t next_request;
    store_reply_t   want;
    int unsigned    burst_left = 0;
    int unsigned    gap_left = 0;
    int unsigned    stall_mode = 0;
    int unsigned    mode_left = 0;
    int unsigned    fault_count = 0;

    predecoded_instruction_store_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .phys_addr    (phys_addr),
        .range_length (range_length),
        .fill_word    (fill_word),
        .fill_op_id   (fill_op_id),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hit          (hit),
        .hit_word     (hit_word),
        .hit_op_id    (hit_op_id)
    );

    always #6 clk = ~clk;

    function automatic void drop_page_entries(int unsigned pg);
        if (pg < DEF_COVERED_PAGES)
            for (int unsigned w = 0; w < WORDS_IN_PAGE; w++)
                entry_live[pg * WORDS_IN_PAGE + w] = 1'b0;
    endfunction

    function automatic store_reply_t apply_request(store_request_t req);
        store_reply_t reply;
        logic [32:0]  span_end;
        int unsigned  slot;
        int unsigned  first_pg;
        int unsigned  last_pg;
        bit           covered;
        reply = '0;
        covered = req.addr[31:PAGE_BITS] < DEF_COVERED_PAGES;
        slot = req.addr[31:PAGE_BITS] * WORDS_IN_PAGE + req.addr[PAGE_BITS-1:2];
        case (req.action)
            ACT_LOOKUP:
            begin
                if (covered && entry_live[slot])
                begin
                    reply.hit = 1'b1;
                    reply.word = entry_word[slot];
                    reply.op_id = entry_op[slot];
                end
            end
            ACT_FILL:
            begin
                if (covered)
                begin
                    entry_word[slot] = req.word;
                    entry_op[slot] = req.op_id;
                    entry_live[slot] = req.op_id != 8'd0;
                end
            end
            ACT_INV_PAGE:
                drop_page_entries(32'(req.addr[31:PAGE_BITS]));
            ACT_INV_RANGE:
            begin
                if (req.len != 32'd0)
                begin
                    span_end = {1'b0, req.addr} + {1'b0, req.len} - 33'd1;
                    if (span_end[32])
                        span_end = 33'h0_FFFF_FFFF;
                    first_pg = 32'(req.addr[31:PAGE_BITS]);
                    last_pg = 32'(span_end[31:PAGE_BITS]);
                    if (last_pg >= DEF_COVERED_PAGES)
                        last_pg = DEF_COVERED_PAGES - 1;
                    for (int unsigned pg = first_pg; pg <= last_pg; pg++)
                        drop_page_entries(pg);
                end
            end
            ACT_CLEAR_ALL:
                for (int unsigned pg = 0; pg < DEF_COVERED_PAGES; pg++)
                    drop_page_entries(pg);
            default:
                ;
        endcase
        return reply;
    endfunction

    function automatic logic [31:0] pick_addr();
        int unsigned pick;
        logic [31:0] page;
        logic [31:0] word;
        pick = $urandom_range(0, 9);
        page = $urandom_range(0, DEF_COVERED_PAGES - 1);
        if (pick == 0)
            return $urandom;
        if (pick == 1)
            word = $urandom_range(0, WORDS_IN_PAGE - 1);
        else
            word = $urandom_range(0, 7);
        return (page << PAGE_BITS) | (word << 2) | 32'($urandom_range(0, 3));
    endfunction

    task automatic add_request(logic [2:0] act, logic [31:0] addr, logic [31:0] len,
                               logic [31:0] word, logic [7:0] op_id);
        store_request_t req;
        req.action = act;
        req.addr = addr;
        req.len = len;
        req.word = word;
        req.op_id = op_id;
        pending_requests = {pending_requests, req};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_replies = {expected_replies, apply_request(cur_request)};
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0 || pending_requests.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (gap_left != 0)
                        gap_left <= gap_left - 1;
                end
                else
                begin
                    next_request = pending_requests.pop_front();
                    cur_request <= next_request;
                    in_valid <= 1'b1;
                    action <= next_request.action;
                    phys_addr <= next_request.addr;
                    range_length <= next_request.len;
                    fill_word <= next_request.word;
                    fill_op_id <= next_request.op_id;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_mode <= 0;
            mode_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_replies.size() == 0)
                begin
                    if (fault_count < 10)
                        $display("unexpected reply: hit=%0b word=%h id=%h",
                                 hit, hit_word, hit_op_id);
                    fault_count <= fault_count + 1;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (hit !== want.hit || hit_word !== want.word || hit_op_id !== want.op_id)
                    begin
                        if (fault_count < 10)
                            $display("mismatch: exp hit=%0b word=%h id=%h, got %0b %h %h",
                                     want.hit, want.word, want.op_id, hit, hit_word, hit_op_id);
                        fault_count <= fault_count + 1;
                    end
                end
            end
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                mode_left <= $urandom_range(20, 80);
            end
            else
                mode_left <= mode_left - 1;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= $urandom_range(0, 3) == 0;
                default: out_stall <= $urandom_range(0, 3) != 0;
            endcase
        end
    end

    initial
    begin
        store_request_t req;
        int unsigned    roll;
        int unsigned    sweeps_left;
        sweeps_left = SWEEP_BUDGET;

        add_request(ACT_LOOKUP, 32'h0000_0000, 32'h0, 32'h0, 8'h01);
        add_request(ACT_FILL, 32'h0000_0000, 32'h0, 32'hFFFF_FFFF, 8'hFF);
        add_request(ACT_LOOKUP, 32'h0000_0003, 32'hFFFF_FFFF, 32'h0, 8'h01);
        add_request(ACT_FILL, 32'h0000_FFFF, 32'h0, 32'h0000_0000, 8'h01);
        add_request(ACT_LOOKUP, 32'h0000_FFFC, 32'h0, 32'h0, 8'h01);
        add_request(ACT_FILL, 32'h0001_0000, 32'h0, 32'h1234_5678, 8'h55);
        add_request(ACT_LOOKUP, 32'h0001_0000, 32'h0, 32'h0, 8'h01);
        add_request(ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 8'h01);
        add_request(ACT_FILL, 32'h0000_1004, 32'h0, 32'hA5A5_A5A5, 8'h80);
        add_request(ACT_FILL, 32'h0000_1004, 32'h0, 32'h5A5A_5A5A, 8'h00);
        add_request(ACT_LOOKUP, 32'h0000_1004, 32'h0, 32'h0, 8'h01);
        add_request(ACT_FILL, 32'h0000_2008, 32'h0, 32'hDEAD_BEEF, 8'h07);
        add_request(ACT_INV_PAGE, 32'h0000_2FFF, 32'h0, 32'h0, 8'h01);
        add_request(ACT_LOOKUP, 32'h0000_2008, 32'h0, 32'h0, 8'h01);
        add_request(ACT_INV_RANGE, 32'h0000_0000, 32'h0, 32'h0, 8'h01);
        add_request(ACT_LOOKUP, 32'h0000_0000, 32'h0, 32'h0, 8'h01);
        add_request(ACT_INV_RANGE, 32'h0000_F000, 32'hFFFF_FFFF, 32'h0, 8'h01);
        add_request(ACT_LOOKUP, 32'h0000_FFFC, 32'h0, 32'h0, 8'h01);
        add_request(ACT_FILL, 32'h0000_3000, 32'h0, 32'h0BAD_F00D, 8'h3C);
        add_request(ACT_INV_RANGE, 32'h0000_0FFE, 32'h3, 32'h0, 8'h01);
        add_request(ACT_LOOKUP, 32'h0000_0000, 32'h0, 32'h0, 8'h01);
        add_request(ACT_LOOKUP, 32'h0000_3000, 32'h0, 32'h0, 8'h01);
        add_request(ACT_INV_PAGE, 32'hFFFF_F123, 32'h0, 32'h0, 8'h01);
        add_request(ACT_RESERVED_A, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        add_request(ACT_RESERVED_B, 32'h0000_3000, 32'h0000_1000, 32'h0, 8'h01);
        add_request(ACT_RESERVED_C, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0, 8'h01);
        add_request(ACT_CLEAR_ALL, 32'h0, 32'h0, 32'h0, 8'h01);
        add_request(ACT_LOOKUP, 32'h0000_3000, 32'h0, 32'h0, 8'h01);

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            roll = $urandom_range(0, 99);
            req.addr = pick_addr();
            req.len = $urandom;
            req.word = $urandom;
            req.op_id = ($urandom_range(0, 29) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
            if (roll >= 85 && roll < 92 && sweeps_left == 0)
                roll = 0;
            if (roll < 50)
                req.action = ACT_LOOKUP;
            else if (roll < 85)
                req.action = ACT_FILL;
            else if (roll < 88)
            begin
                req.action = ACT_INV_PAGE;
                sweeps_left--;
            end
            else if (roll < 91)
            begin
                req.action = ACT_INV_RANGE;
                sweeps_left--;
                case ($urandom_range(0, 9))
                    0: req.len = 32'd0;
                    1: ;
                    default: req.len = $urandom_range(1, 8192);
                endcase
            end
            else if (roll < 92)
            begin
                req.action = ACT_CLEAR_ALL;
                sweeps_left--;
            end
            else if (roll < 95)
                req.action = 3'($urandom_range(ACT_RESERVED_A, ACT_RESERVED_C));
            else
                req.action = ACT_LOOKUP;
            pending_requests = {pending_requests, req};
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_requests.size() != 0 || in_valid || expected_replies.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fault_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
